>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the Mandelbrot pixel colorer.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_IMPL(lbl, clk_sig, rstn_sig, ante, cons)
`define ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons)
`endif
`endif

>>> hw/rtl/mpc_pkg.sv
// Constants, types and sequencer states of the Mandelbrot pixel colorer.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps
`default_nettype none

package mpc_pkg;

    localparam int IMAGE_WIDTH    = 512;
    localparam int IMAGE_HEIGHT   = 512;
    localparam int MAX_ITERATIONS = 256;

    localparam int PIX_W         = 9;
    localparam int COLOR_W       = 8;
    localparam int COUNT_OUT_W   = 9;
    localparam int COUNT_OUT_MAX = (2 ** COUNT_OUT_W) - 1;

    // operand and product widths of the shared multiplier
    localparam int Z_W = 32;
    localparam int P_W = 64;

    localparam int FRAC_Z = 28;
    localparam int FRAC_C = 16;
    localparam int ONE_C  = 65536;
    localparam int SOFT_K = 32113;
    localparam int CH_W   = 20;

    // coordinate mapping: x*5*2^27/W = m*Q + floor(m*R/W), m = x*5
    localparam int MAP_M_W = $clog2((((2 ** PIX_W) - 1) * 5) + 1);
    localparam int MAP_QW  = (2 ** 27) / IMAGE_WIDTH;
    localparam int MAP_RW  = (2 ** 27) % IMAGE_WIDTH;
    localparam int MAP_QH  = (2 ** 27) / IMAGE_HEIGHT;
    localparam int MAP_RH  = (2 ** 27) % IMAGE_HEIGHT;
    localparam int CX_OFS  = 7 * (2 ** 26);
    localparam int CY_OFS  = 5 * (2 ** 26);

    // color fraction: count*2^16/MAX = count*Q + floor(count*R/MAX)
    localparam int T_Q = (2 ** 16) / MAX_ITERATIONS;
    localparam int T_R = (2 ** 16) % MAX_ITERATIONS;

    localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);

    localparam int DIV_Q_W = (MAP_M_W > CNT_W) ? MAP_M_W : CNT_W;
    localparam int DIVISOR_MAX_WH = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam int DIVISOR_MAX = (DIVISOR_MAX_WH > MAX_ITERATIONS) ? DIVISOR_MAX_WH
                                                                  : MAX_ITERATIONS;
    localparam int DIV_D_W = $clog2(DIVISOR_MAX + 1);
    localparam int DIV_N_W = DIV_Q_W + DIV_D_W;

    // reciprocals for the constant divisions: floor(n/d) = (n * ceil(2^DIV_S/d)) >> DIV_S
    localparam int DIV_S   = DIV_N_W + DIV_D_W;
    localparam int DIV_K_W = DIV_S - 3;
    localparam int DIV_P_W = DIV_N_W + DIV_K_W;
    localparam longint DIV_K_X = ((64'sd1 <<< DIV_S) + IMAGE_WIDTH - 1) / IMAGE_WIDTH;
    localparam longint DIV_K_Y = ((64'sd1 <<< DIV_S) + IMAGE_HEIGHT - 1) / IMAGE_HEIGHT;
    localparam longint DIV_K_T = ((64'sd1 <<< DIV_S) + MAX_ITERATIONS - 1) / MAX_ITERATIONS;

    localparam logic [P_W:0] ESC_LIMIT = (P_W + 1)'(1) << 58;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP_MUL0,
        S_MAP_MUL1,
        S_DIVX,
        S_DIVY,
        S_ITER_MUL,
        S_ITER_ADD,
        S_T_MUL,
        S_T_START,
        S_T_DIV,
        S_COL_MUL1,
        S_COL_F,
        S_COL_MUL2,
        S_COL_OUT
    } state_t;

    typedef struct packed {
        logic                  load;
        logic signed [Z_W-1:0] a0;
        logic signed [Z_W-1:0] b0;
        logic signed [Z_W-1:0] a1;
        logic signed [Z_W-1:0] b1;
        logic signed [Z_W-1:0] a2;
        logic signed [Z_W-1:0] b2;
    } mul_req_t;

    typedef struct packed {
        logic signed [P_W-1:0] p0;
        logic signed [P_W-1:0] p1;
        logic signed [P_W-1:0] p2;
    } mul_prod_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_K_W-1:0] recip;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/mandelbrot_pixel_color_core.sv
// Mandelbrot escape-time pixel colorer: sequencer and datapath top level.
// Depends on mpc_pkg, mpc_mul3, mpc_div and assert_macros.svh.
//
// Usage:
//   Request: drive pixel_x / pixel_y and raise start; the request is taken
//   at a rising edge where start is high and busy is low. busy stays high
//   until the pixel is finished.
//   Result: done is high for exactly one cycle with red, green, blue and
//   escape_count valid in that cycle. The receiver cannot stall; the result
//   is gone after that cycle. busy is low in the done cycle, so the next
//   request may be taken at the same edge that takes the result.
//   Order: after the taking edge the sequencer maps the pixel, runs the escape
//   loop and computes the color. R is escape_count + 1, or MAX_ITERATIONS
//   when the point never escapes. The loop runs R + 1 steps, each a multiply
//   state then an add state (shared three-lane multiplier, then add, saturate
//   and escape compare on the z in hand; the last one only tests). Mapping
//   uses the reciprocal divisions for x and y; then come the color fraction
//   and the color steps. Throughput: one pixel at a time.
//   Reset: asynchronous, active low; returns the sequencer to idle and drops
//   a request in flight. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mandelbrot_pixel_color_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [8:0] pixel_x,
    input  wire logic [8:0] pixel_y,
    output logic            done,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue,
    output logic [8:0]      escape_count
);
    import mpc_pkg::*;

    function automatic logic signed [Z_W-1:0] sat_q428(input logic signed [P_W+1:0] v);
        logic signed [P_W+1:0] hi;
        logic signed [P_W+1:0] lo;
        hi = (P_W + 2)'(32'sh7fff_ffff);
        lo = (P_W + 2)'(32'sh8000_0000);
        if (v > hi)
            return 32'sh7fff_ffff;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[Z_W-1:0];
    endfunction

    function automatic logic signed [CH_W+2:0] abs_w(input logic signed [CH_W+2:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [P_W+1:0] zcx_ext(input logic signed [Z_W-1:0] v);
        return (P_W + 2)'(v);
    endfunction

    function automatic logic [COLOR_W-1:0] to_channel(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] s;
        logic [16:0]           s17;
        logic [24:0]           s255;
        s = p >>> FRAC_C;
        if (s < 0)
            s17 = '0;
        else if (s > P_W'(ONE_C))
            s17 = 17'(ONE_C);
        else
            s17 = s[16:0];
        s255 = {s17, 8'b0} - 25'(s17);
        return s255[FRAC_C+COLOR_W-1:FRAC_C];
    endfunction

    state_t state_reg, state_next;

    logic [CNT_W-1:0]       iter_reg,  iter_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   done_reg,  done_next;
    logic [MAP_M_W-1:0]     mx_reg,    mx_next;
    logic [MAP_M_W-1:0]     my_reg,    my_next;
    logic signed [Z_W-1:0]  cx_reg,    cx_next;
    logic signed [Z_W-1:0]  cy_reg,    cy_next;
    logic signed [Z_W-1:0]  zx_reg,    zx_next;
    logic signed [Z_W-1:0]  zy_reg,    zy_next;
    logic signed [CH_W-1:0] vr_reg,    vr_next;
    logic signed [CH_W-1:0] vg_reg,    vg_next;
    logic signed [CH_W-1:0] vb_reg,    vb_next;
    logic signed [CH_W-1:0] fr_reg,    fr_next;
    logic signed [CH_W-1:0] fg_reg,    fg_next;
    logic signed [CH_W-1:0] fb_reg,    fb_next;
    logic [COLOR_W-1:0]     red_reg,   red_next;
    logic [COLOR_W-1:0]     green_reg, green_next;
    logic [COLOR_W-1:0]     blue_reg,  blue_next;
    logic [COUNT_OUT_W-1:0] esc_reg,   esc_next;

    mul_req_t  mul_req;
    mul_prod_t prod;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    mpc_mul3 u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    mpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // datapath terms read by the sequencer
    logic [P_W:0]           sq_sum;
    logic                   escape;
    logic signed [P_W+1:0]  diff_w;
    logic signed [P_W+1:0]  re_w;
    logic signed [P_W+1:0]  im_w;
    logic signed [P_W+1:0]  cx_w;
    logic signed [P_W+1:0]  cy_w;
    logic signed [CH_W+2:0] t_w;
    logic signed [CH_W+2:0] t6_w;
    logic [MAP_M_W-1:0]     mx_in;
    logic [MAP_M_W-1:0]     my_in;

    assign sq_sum = {1'b0, prod.p0} + {1'b0, prod.p1};
    assign escape = (sq_sum > ESC_LIMIT);
    assign diff_w = (P_W + 2)'($signed(prod.p0)) - (P_W + 2)'($signed(prod.p1));
    assign re_w   = (diff_w >>> FRAC_Z) + (P_W + 2)'(zcx_ext(cx_reg));
    assign im_w   = ((P_W + 2)'($signed(prod.p2)) >>> (FRAC_Z - 1))
                  + (P_W + 2)'(zcx_ext(cy_reg));
    assign cx_w   = (P_W + 2)'($signed(prod.p0)) + (P_W + 2)'(div_rsp.quot)
                  - (P_W + 2)'(CX_OFS);
    assign cy_w   = (P_W + 2)'($signed(prod.p1)) + (P_W + 2)'(div_rsp.quot)
                  - (P_W + 2)'(CY_OFS);
    assign t_w    = (CH_W + 3)'(prod.p0[CH_W-1:0]) + (CH_W + 3)'(div_rsp.quot);
    assign t6_w   = (t_w <<< 2) + (t_w <<< 1);
    assign mx_in  = (MAP_M_W'(pixel_x) << 2) + MAP_M_W'(pixel_x);
    assign my_in  = (MAP_M_W'(pixel_y) << 2) + MAP_M_W'(pixel_y);

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        mx_next    = mx_reg;
        my_next    = my_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        zx_next    = zx_reg;
        zy_next    = zy_reg;
        vr_next    = vr_reg;
        vg_next    = vg_reg;
        vb_next    = vb_reg;
        fr_next    = fr_reg;
        fg_next    = fg_reg;
        fb_next    = fb_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        esc_next   = esc_reg;
        mul_req    = '0;
        div_req    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mx_next    = mx_in;
                    my_next    = my_in;
                    state_next = S_MAP_MUL0;
                end
            end
            S_MAP_MUL0:
            begin
                mul_req.load = 1'b1;
                mul_req.a0   = Z_W'(mx_reg);
                mul_req.b0   = Z_W'(MAP_QW);
                mul_req.a1   = Z_W'(my_reg);
                mul_req.b1   = Z_W'(MAP_QH);
                mul_req.a2   = Z_W'(mx_reg);
                mul_req.b2   = Z_W'(MAP_RW);
                state_next   = S_MAP_MUL1;
            end
            S_MAP_MUL1:
            begin
                // keep the whole parts in lanes 0/1, load y remainder in lane 2
                mul_req.load     = 1'b1;
                mul_req.a0       = Z_W'(mx_reg);
                mul_req.b0       = Z_W'(MAP_QW);
                mul_req.a1       = Z_W'(my_reg);
                mul_req.b1       = Z_W'(MAP_QH);
                mul_req.a2       = Z_W'(my_reg);
                mul_req.b2       = Z_W'(MAP_RH);
                div_req.start    = 1'b1;
                div_req.dividend = prod.p2[DIV_N_W-1:0];
                div_req.recip    = DIV_K_W'(DIV_K_X);
                state_next       = S_DIVX;
            end
            S_DIVX:
            begin
                if (div_rsp.done)
                begin
                    cx_next          = sat_q428(cx_w);
                    div_req.start    = 1'b1;
                    div_req.dividend = prod.p2[DIV_N_W-1:0];
                    div_req.recip    = DIV_K_W'(DIV_K_Y);
                    state_next       = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_rsp.done)
                begin
                    cy_next    = sat_q428(cy_w);
                    zx_next    = '0;
                    zy_next    = '0;
                    iter_next  = '0;
                    state_next = S_ITER_MUL;
                end
            end
            S_ITER_MUL:
            begin
                mul_req.load = 1'b1;
                mul_req.a0   = zx_reg;
                mul_req.b0   = zx_reg;
                mul_req.a1   = zy_reg;
                mul_req.b1   = zy_reg;
                mul_req.a2   = zx_reg;
                mul_req.b2   = zy_reg;
                state_next   = S_ITER_ADD;
            end
            S_ITER_ADD:
            begin
                // squares on hand belong to the z left by the previous round
                if (escape)
                begin
                    count_next = iter_reg - CNT_W'(1);
                    state_next = S_T_MUL;
                end
                else if (iter_reg == CNT_W'(MAX_ITERATIONS))
                begin
                    count_next = iter_reg;
                    state_next = S_T_MUL;
                end
                else
                begin
                    zx_next    = sat_q428(re_w);
                    zy_next    = sat_q428(im_w);
                    iter_next  = iter_reg + CNT_W'(1);
                    state_next = S_ITER_MUL;
                end
            end
            S_T_MUL:
            begin
                mul_req.load = 1'b1;
                mul_req.a0   = Z_W'(count_reg);
                mul_req.b0   = Z_W'(T_Q);
                mul_req.a1   = Z_W'(count_reg);
                mul_req.b1   = Z_W'(T_R);
                state_next   = S_T_START;
            end
            S_T_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = prod.p1[DIV_N_W-1:0];
                div_req.recip    = DIV_K_W'(DIV_K_T);
                state_next       = S_T_DIV;
            end
            S_T_DIV:
            begin
                if (div_rsp.done)
                begin
                    vr_next    = CH_W'(abs_w(t6_w - (CH_W + 3)'(3 * ONE_C)) - (CH_W + 3)'(ONE_C));
                    vg_next    = CH_W'((CH_W + 3)'(2 * ONE_C) - abs_w(t6_w - (CH_W + 3)'(2 * ONE_C)));
                    vb_next    = CH_W'((CH_W + 3)'(2 * ONE_C) - abs_w(t6_w - (CH_W + 3)'(4 * ONE_C)));
                    state_next = S_COL_MUL1;
                end
            end
            S_COL_MUL1:
            begin
                mul_req.load = 1'b1;
                mul_req.a0   = Z_W'(vr_reg);
                mul_req.b0   = Z_W'(SOFT_K);
                mul_req.a1   = Z_W'(vg_reg);
                mul_req.b1   = Z_W'(SOFT_K);
                mul_req.a2   = Z_W'(vb_reg);
                mul_req.b2   = Z_W'(SOFT_K);
                state_next   = S_COL_F;
            end
            S_COL_F:
            begin
                fr_next    = CH_W'(P_W'(ONE_C) - ($signed(prod.p0) >>> FRAC_C));
                fg_next    = CH_W'(P_W'(ONE_C) - ($signed(prod.p1) >>> FRAC_C));
                fb_next    = CH_W'(P_W'(ONE_C) - ($signed(prod.p2) >>> FRAC_C));
                state_next = S_COL_MUL2;
            end
            S_COL_MUL2:
            begin
                mul_req.load = 1'b1;
                mul_req.a0   = Z_W'(vr_reg);
                mul_req.b0   = Z_W'(fr_reg);
                mul_req.a1   = Z_W'(vg_reg);
                mul_req.b1   = Z_W'(fg_reg);
                mul_req.a2   = Z_W'(vb_reg);
                mul_req.b2   = Z_W'(fb_reg);
                state_next   = S_COL_OUT;
            end
            S_COL_OUT:
            begin
                red_next   = to_channel(prod.p0);
                green_next = to_channel(prod.p1);
                blue_next  = to_channel(prod.p2);
                if (32'(count_reg) > 32'(COUNT_OUT_MAX))
                    esc_next = COUNT_OUT_W'(COUNT_OUT_MAX);
                else
                    esc_next = COUNT_OUT_W'(count_reg);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        zx_reg    <= zx_next;
        zy_reg    <= zy_next;
        vr_reg    <= vr_next;
        vg_reg    <= vg_next;
        vb_reg    <= vb_next;
        fr_reg    <= fr_next;
        fg_reg    <= fg_next;
        fb_reg    <= fb_next;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        esc_reg   <= esc_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign escape_count = esc_reg;

    // a taken request must leave idle
    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    // the result strobe comes only on the way back to idle
    `ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy)
    // z = 0 cannot escape, so an escape never shows before the first round
    `ASSERT_IMPL(a_no_early_escape, clk, rst_n, (state_reg == S_ITER_ADD) && escape, iter_reg != '0)
    // the divider finishes only while the sequencer waits for it
    `ASSERT_IMPL(a_div_done_wait, clk, rst_n, div_rsp.done,
        (state_reg == S_DIVX) || (state_reg == S_DIVY) || (state_reg == S_T_DIV))

endmodule

`default_nettype wire

>>> hw/rtl/mpc_mul3.sv
// Shared three-lane signed multiplier with registered products.
// Depends on mpc_pkg for the request and product types.
`timescale 1ns / 1ps
`default_nettype none

module mpc_mul3 (
    input  wire logic              clk,
    input  wire mpc_pkg::mul_req_t req,
    output mpc_pkg::mul_prod_t     prod
);
    import mpc_pkg::*;

    logic signed [P_W-1:0] p0_reg;
    logic signed [P_W-1:0] p1_reg;
    logic signed [P_W-1:0] p2_reg;

    // hold the products until the sequencer loads new operands
    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            p0_reg <= $signed(req.a0) * $signed(req.b0);
            p1_reg <= $signed(req.a1) * $signed(req.b1);
            p2_reg <= $signed(req.a2) * $signed(req.b2);
        end
    end

    assign prod.p0 = p0_reg;
    assign prod.p1 = p1_reg;
    assign prod.p2 = p2_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mpc_div.sv
// Division by a constant through a reciprocal product; quotient registered, valid in the cycle after start.
// Depends on mpc_pkg; the dividend must be below divisor * 2^DIV_Q_W.
`timescale 1ns / 1ps
`default_nettype none

module mpc_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mpc_pkg::div_req_t req,
    output mpc_pkg::div_rsp_t      rsp
);
    import mpc_pkg::*;

    logic               done_reg, done_next;
    logic [DIV_Q_W-1:0] quot_reg, quot_next;

    logic [DIV_P_W-1:0] prod;

    // exact for every dividend below 2^DIV_N_W since the divisor is below 2^DIV_D_W
    assign prod = DIV_P_W'(req.dividend) * DIV_P_W'(req.recip);

    always_comb
    begin
        done_next = req.start;
        quot_next = quot_reg;
        if (req.start)
        begin
            quot_next = prod[DIV_S +: DIV_Q_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for mandelbrot_pixel_color_core: directed and random pixel requests.
// Depends on mpc_pkg for the image size and iteration limit.
// The escape-time and color predictor below is a bit-exact model of the block.
`timescale 1ns / 1ps

module testbench;

    localparam longint COLOR_ONE   = 65536;
    localparam longint SOFT_FACTOR = 32113;
    localparam longint Q428_HI     = 64'sd2147483647;
    localparam longint Q428_LO     = -64'sd2147483648;
    localparam longint unsigned ESCAPE_BOUND = 64'd4 << 56;
    localparam int RANDOM_PIXELS = 530;
    localparam int DRAIN_CYCLES  = 600;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] count;
    } pixel_color_t;

    typedef struct {
        logic [8:0]   x;
        logic [8:0]   y;
        bit           typed;
        pixel_color_t color;
    } pixel_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [8:0] pixel_x = '0;
    logic [8:0] pixel_y = '0;
    logic       busy;
    logic       done;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] escape_count;

    pixel_color_t predicted_colors[$];
    int           errors = 0;

    // Corners, set interior, real axis near the cusp, single-bit and alternating patterns.
    // In-set points and first-round escapes both land on the same deep red.
    pixel_row_t pixel_rows [0:19] = '{
        '{9'd0,   9'd0,   1'b1, {8'd10, 8'd0, 8'd0, 9'd0}},
        '{9'd0,   9'd511, 1'b1, {8'd10, 8'd0, 8'd0, 9'd0}},
        '{9'd256, 9'd256, 1'b1, {8'd10, 8'd0, 8'd0, 9'd256}},
        '{9'd358, 9'd256, 1'b1, {8'd10, 8'd0, 8'd0, 9'd256}},
        '{9'd511, 9'd0,   1'b0, '0},
        '{9'd511, 9'd511, 1'b0, '0},
        '{9'd0,   9'd256, 1'b0, '0},
        '{9'd511, 9'd256, 1'b0, '0},
        '{9'd400, 9'd256, 1'b0, '0},
        '{9'd409, 9'd256, 1'b0, '0},
        '{9'd410, 9'd256, 1'b0, '0},
        '{9'd128, 9'd256, 1'b0, '0},
        '{9'd1,   9'd2,   1'b0, '0},
        '{9'd4,   9'd8,   1'b0, '0},
        '{9'd16,  9'd32,  1'b0, '0},
        '{9'd64,  9'd128, 1'b0, '0},
        '{9'd128, 9'd64,  1'b0, '0},
        '{9'h155, 9'h0AA, 1'b0, '0},
        '{9'h0AA, 9'h155, 1'b0, '0},
        '{9'd300, 9'd330, 1'b0, '0}
    };

    mandelbrot_pixel_color_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .done         (done),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .escape_count (escape_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint clamp_q428(input longint v);
        if (v > Q428_HI)
            return Q428_HI;
        if (v < Q428_LO)
            return Q428_LO;
        return v;
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Soften by (1 - 0.49*v), clamp to [0,1] and scale to 8 bits.
    function automatic logic [7:0] soften_channel(input longint v);
        longint f;
        longint s;
        f = COLOR_ONE - ((v * SOFT_FACTOR) >>> 16);
        s = (v * f) >>> 16;
        if (s < 0)
            s = 0;
        if (s > COLOR_ONE)
            s = COLOR_ONE;
        return 8'((s * 255) >>> 16);
    endfunction

    function automatic pixel_color_t predict_pixel_color(input logic [8:0] x,
                                                         input logic [8:0] y);
        longint cx;
        longint cy;
        longint zx;
        longint zy;
        longint re;
        longint im;
        longint t;
        longint unsigned ax;
        longint unsigned ay;
        int n;
        pixel_color_t c;
        cx = clamp_q428((longint'(x) * 5 * (64'sd1 <<< 27)) / mpc_pkg::IMAGE_WIDTH
                        - 7 * (64'sd1 <<< 26));
        cy = clamp_q428((longint'(y) * 5 * (64'sd1 <<< 27)) / mpc_pkg::IMAGE_HEIGHT
                        - 5 * (64'sd1 <<< 26));
        zx = 0;
        zy = 0;
        for (n = 0; n < mpc_pkg::MAX_ITERATIONS; n++)
        begin
            re = ((zx * zx - zy * zy) >>> 28) + cx;
            im = ((zx * zy) >>> 27) + cy;
            zx = clamp_q428(re);
            zy = clamp_q428(im);
            ax = magnitude(zx);
            ay = magnitude(zy);
            if (ax * ax + ay * ay > ESCAPE_BOUND)
                break;
        end
        t = (longint'(n) * COLOR_ONE) / mpc_pkg::MAX_ITERATIONS;
        c.red   = soften_channel(magnitude(6 * t - 3 * COLOR_ONE) - COLOR_ONE);
        c.green = soften_channel(2 * COLOR_ONE - magnitude(6 * t - 2 * COLOR_ONE));
        c.blue  = soften_channel(2 * COLOR_ONE - magnitude(6 * t - 4 * COLOR_ONE));
        c.count = (n > 511) ? 9'd511 : 9'(n);
        return c;
    endfunction

    // Enter and leave at a falling edge; hold the request until the block takes it.
    task automatic issue_pixel(input logic [8:0] x, input logic [8:0] y,
                               input pixel_color_t color, input bit allow_idle);
        int gap;
        gap = 0;
        if (allow_idle)
        begin
            while ($urandom_range(99) < 22)
                gap++;
            if ($urandom_range(9) == 0)
                gap += $urandom_range(600);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            pixel_x <= 9'($urandom);
            pixel_y <= 9'($urandom);
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        do
            @(posedge clk);
        while (busy);
        predicted_colors.push_back(color);
        @(negedge clk);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        pixel_color_t want;
        if (rst_n && done)
        begin
            if (predicted_colors.size() == 0)
            begin
                $display("%0t ns: result with no request pending, expected none, got %0d %0d %0d %0d",
                         $time, red, green, blue, escape_count);
                errors++;
            end
            else
            begin
                want = predicted_colors.pop_front();
                compare_field("red", want.red, red);
                compare_field("green", want.green, green);
                compare_field("blue", want.blue, blue);
                compare_field("escape_count", want.count, escape_count);
            end
        end
    end

    initial
    begin
        int k;
        logic [8:0] x;
        logic [8:0] y;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (k = 0; k < $size(pixel_rows); k++)
        begin
            x = pixel_rows[k].x;
            y = pixel_rows[k].y;
            issue_pixel(x, y, pixel_rows[k].typed ? pixel_rows[k].color
                                                  : predict_pixel_color(x, y), 1'b1);
        end

        // Mix the whole image with a window around the set boundary for varied counts.
        for (k = 0; k < RANDOM_PIXELS; k++)
        begin
            if ($urandom_range(99) < 60)
            begin
                x = 9'($urandom_range(511));
                y = 9'($urandom_range(511));
            end
            else
            begin
                x = 9'($urandom_range(420, 200));
                y = 9'($urandom_range(362, 150));
            end
            issue_pixel(x, y, predict_pixel_color(x, y), !(k >= 150 && k < 300));
        end
        start <= 1'b0;

        while (predicted_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
